FILE: rtl/ofc_pkg.sv
// Shared constants, codes and controller/datapath interface types for the FIR convolver.
package ofc_pkg;

    // Item field widths
    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 2 * (SAMPLE_BITS - 1);
    localparam int OUT_W       = 38;
    localparam int TAP_IDX_W   = 6;
    localparam int TAP_CNT_W   = 7;

    // Default filter depth
    localparam int MAX_TAPS_DEF = 64;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INT_OUTPUT = 2'd1;

    // Operation codes of an input item
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic push;      // write sample into history, restart the tap walk
        logic coef_wr;   // write coefficient slot
        logic issue;     // read one tap pair into the MAC pipeline
        logic load_out;  // move the finished sum into the output register
        logic int_mode;  // truncate to integer part on load
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic out_valid; // output register holds an item
    } t_status;

endpackage

FILE: rtl/ofc_datapath.sv
// Datapath: coefficient and history memories, multiply-accumulate pipeline, output register.
module ofc_datapath #(
    parameter int MAX_TAPS = ofc_pkg::MAX_TAPS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ofc_pkg::t_cmd                       i_cmd,
    output ofc_pkg::t_status                    o_status,
    input  logic [ofc_pkg::TAP_IDX_W-1:0]       i_tap_index,
    input  logic signed [ofc_pkg::SAMPLE_BITS-1:0] i_value,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output logic signed [ofc_pkg::OUT_W-1:0]    o_filtered
);

    localparam int AW     = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int KW     = $clog2(MAX_TAPS + 1);
    localparam int SB     = ofc_pkg::SAMPLE_BITS;
    localparam int PW     = 2 * SB;
    localparam int ACC_W  = PW + KW;
    localparam int FRAC   = ofc_pkg::FRAC_BITS;

    logic signed [SB-1:0] r_coef_mem [MAX_TAPS];
    logic signed [SB-1:0] r_hist_mem [MAX_TAPS];

    logic [AW-1:0]           r_newest;
    logic [AW-1:0]           n_newest;
    logic [AW-1:0]           r_rd_slot;
    logic [KW-1:0]           r_rd_k;
    logic [KW-1:0]           r_fill;
    logic signed [SB-1:0]    r_coef_q;
    logic signed [SB-1:0]    r_hist_q;
    logic                    r_v1;
    logic signed [PW-1:0]    r_prod;
    logic                    r_v2;
    logic signed [ACC_W-1:0] r_acc;
    logic                    r_out_valid;
    logic signed [ofc_pkg::OUT_W-1:0] r_filtered;

    logic signed [ACC_W-1:0] trunc_bias;
    logic signed [ACC_W-1:0] trunc_sum;
    logic signed [ACC_W-1:0] int_part;
    logic signed [ACC_W-1:0] out_sum;

    // Next history slot, circular
    assign n_newest = (r_newest == AW'(MAX_TAPS - 1)) ? '0 : r_newest + AW'(1);

    // Coefficient memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.coef_wr) begin
            r_coef_mem[AW'(i_tap_index)] <= i_value;
        end
        if (i_cmd.issue) begin
            r_coef_q <= r_coef_mem[r_rd_k[AW-1:0]];
        end
    end

    // History memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_hist_mem[n_newest] <= i_value;
        end
        if (i_cmd.issue) begin
            r_hist_q <= r_hist_mem[r_rd_slot];
        end
    end

    // Walk pointers, fill count and pipeline valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_newest  <= '0;
            r_rd_slot <= '0;
            r_rd_k    <= '0;
            r_fill    <= '0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
        end else begin
            if (i_cmd.push) begin
                r_newest  <= n_newest;
                r_rd_slot <= n_newest;
                r_rd_k    <= '0;
                if (r_fill != KW'(MAX_TAPS)) begin
                    r_fill <= r_fill + KW'(1);
                end
            end else if (i_cmd.issue) begin
                r_rd_slot <= (r_rd_slot == '0) ? AW'(MAX_TAPS - 1) : r_rd_slot - AW'(1);
                r_rd_k    <= r_rd_k + KW'(1);
            end
            // a slot never pushed reads as zero: mask it by the fill count
            r_v1 <= i_cmd.issue && (r_rd_k < r_fill);
            r_v2 <= r_v1;
        end
    end

    // Multiply, then accumulate
    always_ff @(posedge i_clk) begin
        r_prod <= r_coef_q * r_hist_q;
        if (i_cmd.push) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    // Truncation toward zero: bias negative sums before the arithmetic shift
    assign trunc_bias = r_acc[ACC_W-1] ? ACC_W'((64'd1 << FRAC) - 64'd1) : '0;
    assign trunc_sum  = r_acc + trunc_bias;
    assign int_part   = trunc_sum >>> FRAC;
    assign out_sum    = i_cmd.int_mode ? int_part : r_acc;

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_filtered <= ofc_pkg::OUT_W'(out_sum);
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_filtered         = r_filtered;
    assign o_status.out_valid = r_out_valid;

    // The sum is only taken once the MAC pipeline has emptied
    a_drained_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> (!r_v1 && !r_v2))
        else $error("result loaded with taps still in flight");

    // A held result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> (!r_out_valid || !i_out_stall))
        else $error("output register overwritten while stalled");

endmodule

FILE: rtl/ofc_ctrl.sv
// Controller: configuration registers and the tap-walk sequencer for each sample item.
module ofc_ctrl #(
    parameter int MAX_TAPS = ofc_pkg::MAX_TAPS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_operation,
    input  logic [ofc_pkg::TAP_IDX_W-1:0]      i_tap_index,
    input  logic                               i_out_stall,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [ofc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ofc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output ofc_pkg::t_cmd                      o_cmd,
    input  ofc_pkg::t_status                   i_status
);

    localparam int KW = $clog2(MAX_TAPS + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_MAC   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_LOAD  = 2'd3;

    logic [1:0]                      r_state;
    logic [1:0]                      n_state;
    logic [KW-1:0]                   r_k;
    logic [KW-1:0]                   n_k;
    logic                            r_drain;
    logic                            n_drain;
    logic [ofc_pkg::TAP_CNT_W-1:0]   r_tap_count;
    logic                            r_int_mode;

    logic [KW-1:0] taps_eff;
    logic          in_acc;
    logic          out_free;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= ofc_pkg::TAP_CNT_W'(1);
            r_int_mode  <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ofc_pkg::CFG_TAP_COUNT:  r_tap_count <= i_cfg_data;
                ofc_pkg::CFG_INT_OUTPUT: r_int_mode  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // Tap count in use, saturated to the table depth
    assign taps_eff = (32'(r_tap_count) > MAX_TAPS) ? KW'(MAX_TAPS) : KW'(r_tap_count);

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !i_status.out_valid || !i_out_stall;

    // Sequencer
    always_comb begin
        n_state        = r_state;
        n_k            = r_k;
        n_drain        = r_drain;
        o_cmd          = '0;
        o_cmd.int_mode = r_int_mode;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_operation == ofc_pkg::OP_LOAD) begin
                        o_cmd.coef_wr = (32'(i_tap_index) < MAX_TAPS);
                    end else begin
                        o_cmd.push = 1'b1;
                        n_k        = '0;
                        n_drain    = 1'b0;
                        n_state    = (taps_eff == '0) ? S_DRAIN : S_MAC;
                    end
                end
            end
            S_MAC: begin
                o_cmd.issue = 1'b1;
                n_k         = r_k + KW'(1);
                if (n_k == taps_eff) begin
                    n_drain = 1'b0;
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // drain the multiply stage, then the accumulate stage
                n_drain = 1'b1;
                if (r_drain) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_drain <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_drain <= n_drain;
        end
    end

    // A sample item always starts a walk
    a_push_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_operation == ofc_pkg::OP_PUSH) |=> (r_state != S_IDLE))
        else $error("sample item accepted without starting a tap walk");

    // Tap counter stays inside the taps in use
    a_k_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAC) |-> (r_k < taps_eff))
        else $error("tap counter past tap count");

    // Result is loaded only after the drain cycles
    a_load_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> ($past(r_state) == S_DRAIN || $past(r_state) == S_LOAD))
        else $error("result loaded without draining the pipeline");

endmodule

FILE: rtl/overlap_add_fir_convolver.sv
// Top level of the Q15 FIR convolver: controller and datapath joined by command and status.
// A sample item walks T taps, T = taps in use (tap_count, max MAX_TAPS), then drains the pipeline.
// The single shared multiply-accumulate reads one tap per cycle; a stalled output delays the load.
// A coefficient item is taken while idle; the input stalls until a sample's result is loaded.
// Synchronous active-low reset clears history (by fill count), tap_count to 1, integer mode off.
// Coefficients are undefined until written; configuration writes are taken every cycle.
module overlap_add_fir_convolver #(
    parameter int MAX_TAPS = ofc_pkg::MAX_TAPS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic                                   i_operation,
    input  logic [ofc_pkg::TAP_IDX_W-1:0]          i_tap_index,
    input  logic signed [ofc_pkg::SAMPLE_BITS-1:0] i_value,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [ofc_pkg::OUT_W-1:0]       o_filtered,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [ofc_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [ofc_pkg::CFG_DATA_W-1:0]         i_cfg_data
);

    ofc_pkg::t_cmd    cmd;
    ofc_pkg::t_status status;

    ofc_ctrl #(
        .MAX_TAPS (MAX_TAPS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_operation (i_operation),
        .i_tap_index (i_tap_index),
        .i_out_stall (i_out_stall),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    ofc_datapath #(
        .MAX_TAPS (MAX_TAPS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_tap_index (i_tap_index),
        .i_value     (i_value),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_filtered  (o_filtered)
    );

endmodule

FILE: verif/tb_overlap_add_fir_convolver.sv
// Self-checking testbench for the Q15 FIR convolver: scoreboard, stimulus, stalls and watchdog.
module tb_overlap_add_fir_convolver;

    localparam int SETTLE_CYC     = 8;     // wait after the last result is checked
    localparam int LONG_HOLD      = 300;   // long output hold-off, fills the block
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake before giving up

    // Scoreboard: tracks taps, history and mode, predicts each filtered result
    class fir_tracker;
        logic signed [ofc_pkg::SAMPLE_BITS-1:0] coef_tbl [ofc_pkg::MAX_TAPS_DEF];
        logic signed [ofc_pkg::SAMPLE_BITS-1:0] sample_line [ofc_pkg::MAX_TAPS_DEF];
        int unsigned                   newest;
        int unsigned                   taps_reg;
        bit                            int_mode;
        logic signed [ofc_pkg::OUT_W-1:0] pending_sums [$];
        int errors, samples, loads, checked, cfg_writes;

        function new();
            foreach (coef_tbl[i]) coef_tbl[i] = '0;
            foreach (sample_line[i]) sample_line[i] = '0;
            newest     = 0;
            taps_reg   = 1;
            int_mode   = 1'b0;
            errors     = 0;
            samples    = 0;
            loads      = 0;
            checked    = 0;
            cfg_writes = 0;
        endfunction

        function void set_register(logic [ofc_pkg::CFG_IDX_W-1:0] idx,
                                   logic [ofc_pkg::CFG_DATA_W-1:0] data);
            if (idx == ofc_pkg::CFG_TAP_COUNT) begin
                taps_reg = 32'(data);
            end else if (idx == ofc_pkg::CFG_INT_OUTPUT) begin
                int_mode = data[0];
            end
            cfg_writes++;
        endfunction

        // Accepted input item: load a tap, or push a sample and predict its sum
        function void note_item(logic op, logic [ofc_pkg::TAP_IDX_W-1:0] idx,
                                logic signed [ofc_pkg::SAMPLE_BITS-1:0] val);
            longint      acc;
            int unsigned used;
            int unsigned slot;
            if (op == ofc_pkg::OP_LOAD) begin
                coef_tbl[idx] = val;
                loads++;
                return;
            end
            samples++;
            newest = (newest + 1) % ofc_pkg::MAX_TAPS_DEF;
            sample_line[newest] = val;
            used = (taps_reg > ofc_pkg::MAX_TAPS_DEF) ? ofc_pkg::MAX_TAPS_DEF : taps_reg;
            acc  = 0;
            for (int k = 0; k < used; k++) begin
                slot = (newest + ofc_pkg::MAX_TAPS_DEF - k) % ofc_pkg::MAX_TAPS_DEF;
                acc += longint'(coef_tbl[k]) * longint'(sample_line[slot]);
            end
            // signed division truncates toward zero
            if (int_mode) acc = acc / (longint'(1) <<< ofc_pkg::FRAC_BITS);
            pending_sums.push_back(acc[ofc_pkg::OUT_W-1:0]);
        endfunction

        function void check_filtered(logic signed [ofc_pkg::OUT_W-1:0] act);
            logic signed [ofc_pkg::OUT_W-1:0] want;
            if (pending_sums.size() == 0) begin
                errors++;
                if (errors <= 20)
                    $display("%0t: unexpected filtered result %0d, nothing expected", $time, act);
                return;
            end
            want = pending_sums.pop_front();
            checked++;
            if (act !== want) begin
                errors++;
                if (errors <= 20)
                    $display("%0t: filtered mismatch, expected %0d, actual %0d", $time, want, act);
            end
        endfunction
    endclass

    logic                                   i_clk;
    logic                                   i_rst_n;
    logic                                   i_in_valid;
    logic                                   o_in_stall;
    logic                                   i_operation;
    logic [ofc_pkg::TAP_IDX_W-1:0]          i_tap_index;
    logic signed [ofc_pkg::SAMPLE_BITS-1:0] i_value;
    logic                                   o_out_valid;
    logic                                   i_out_stall;
    logic signed [ofc_pkg::OUT_W-1:0]       o_filtered;
    logic                                   i_cfg_valid;
    logic                                   o_cfg_ready;
    logic [ofc_pkg::CFG_IDX_W-1:0]          i_cfg_index;
    logic [ofc_pkg::CFG_DATA_W-1:0]         i_cfg_data;

    fir_tracker trk = new();
    bit         tx_gaps   = 1'b1;
    bit         rx_gaps   = 1'b1;
    bit         hold_long = 1'b0;
    int         quiet_cycles = 0;

    overlap_add_fir_convolver dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_operation (i_operation),
        .i_tap_index (i_tap_index),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_filtered  (o_filtered),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall)
            trk.note_item(i_operation, i_tap_index, i_value);
        if (i_rst_n && o_out_valid && !i_out_stall)
            trk.check_filtered(o_filtered);
        if (i_rst_n && i_cfg_valid && o_cfg_ready)
            trk.set_register(i_cfg_index, i_cfg_data);
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Result receiver: random stall per item, one long hold-off on request
    initial begin : receiver
        int n;
        forever begin
            n = rx_gaps ? $urandom_range(0, 4) : 0;
            if (hold_long) begin
                n = LONG_HOLD;
                hold_long = 1'b0;
            end
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // Edge values half the time, otherwise any 16-bit value
    function automatic logic signed [ofc_pkg::SAMPLE_BITS-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return '0;
            3:       return '1;
            default: return 16'($urandom);
        endcase
    endfunction

    // Offer one item after a random gap (when tx_gaps is set); valid stays high on return
    task automatic send_item(input logic op, input logic [ofc_pkg::TAP_IDX_W-1:0] idx,
                             input logic signed [ofc_pkg::SAMPLE_BITS-1:0] val);
        int gap;
        gap = tx_gaps ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_tap_index <= idx;
        i_value     <= val;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Stop offering and wait until every predicted result has come out
    task automatic drain_results();
        i_in_valid <= 1'b0;
        // let the monitor note the last accepted item first
        @(posedge i_clk);
        while (trk.pending_sums.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // Both registers, back to back; only called with the block idle
    task automatic write_config(input logic [ofc_pkg::TAP_CNT_W-1:0] taps, input bit int_bit);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= ofc_pkg::CFG_TAP_COUNT;
        i_cfg_data  <= taps;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= ofc_pkg::CFG_INT_OUTPUT;
        i_cfg_data  <= {6'($urandom), int_bit};  // only bit 0 matters
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic load_all_taps(input bit all_min);
        for (int i = 0; i < ofc_pkg::MAX_TAPS_DEF; i++)
            send_item(ofc_pkg::OP_LOAD, ofc_pkg::TAP_IDX_W'(i),
                      all_min ? 16'sh8000 : pick_value());
    endtask

    task automatic run_phase(input int n_items, input logic [ofc_pkg::TAP_CNT_W-1:0] taps,
                             input bit pause_mid);
        write_config(taps, 1'($urandom));
        for (int i = 0; i < n_items; i++) begin
            if (pause_mid && i == n_items / 2) drain_results();
            if ($urandom_range(0, 6) == 0)
                send_item(ofc_pkg::OP_LOAD, ofc_pkg::TAP_IDX_W'($urandom), pick_value());
            else
                send_item(ofc_pkg::OP_PUSH, ofc_pkg::TAP_IDX_W'($urandom), pick_value());
        end
        drain_results();
    endtask

    initial begin : stimulus
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_operation <= ofc_pkg::OP_PUSH;
        i_tap_index <= '0;
        i_value     <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= ofc_pkg::CFG_TAP_COUNT;
        i_cfg_data  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: one tap, Q30 output; tap index ignored on pushes
        send_item(ofc_pkg::OP_LOAD, 6'd0, 16'sh8000);
        send_item(ofc_pkg::OP_PUSH, 6'd0, 16'sh8000);
        send_item(ofc_pkg::OP_PUSH, 6'd63, 16'sh7FFF);
        send_item(ofc_pkg::OP_LOAD, 6'd0, 16'sh7FFF);
        send_item(ofc_pkg::OP_PUSH, 6'h2A, 16'sh8000);
        send_item(ofc_pkg::OP_PUSH, 6'h15, 16'sh0000);
        send_item(ofc_pkg::OP_LOAD, 6'd1, 16'sh8000);
        send_item(ofc_pkg::OP_LOAD, 6'd63, 16'sh7FFF);
        drain_results();

        // Two taps, integer output: truncation of both signs
        write_config(7'd2, 1'b1);
        send_item(ofc_pkg::OP_PUSH, 6'd0, 16'sh8000);
        send_item(ofc_pkg::OP_PUSH, 6'd63, 16'sh8000);
        send_item(ofc_pkg::OP_PUSH, 6'd1, 16'sh7FFF);
        send_item(ofc_pkg::OP_PUSH, 6'd0, 16'sh7FFF);
        send_item(ofc_pkg::OP_PUSH, 6'd7, 16'shFFFF);
        send_item(ofc_pkg::OP_PUSH, 6'd0, 16'sh0001);
        drain_results();

        // Zero taps sum to zero
        write_config(7'd0, 1'b0);
        send_item(ofc_pkg::OP_PUSH, 6'h15, 16'sh1234);
        send_item(ofc_pkg::OP_LOAD, 6'd2, 16'sh5555);
        send_item(ofc_pkg::OP_PUSH, 6'h3F, 16'sh8000);
        drain_results();

        // Largest sum: every tap and sample at the negative extreme
        load_all_taps(1'b1);
        drain_results();
        write_config(7'd64, 1'b0);
        for (int i = 0; i < 66; i++) send_item(ofc_pkg::OP_PUSH, 6'($urandom), 16'sh8000);
        drain_results();
        write_config(7'd127, 1'b1);
        for (int i = 0; i < 3; i++) send_item(ofc_pkg::OP_PUSH, 6'($urandom), 16'sh8000);
        send_item(ofc_pkg::OP_LOAD, 6'd0, 16'sh7FFF);
        send_item(ofc_pkg::OP_PUSH, 6'd0, 16'sh7FFF);
        drain_results();

        // Random taps, then random phases over the tap count range
        load_all_taps(1'b0);
        drain_results();
        run_phase(30, 7'($urandom_range(1, 64)), 1'b0);
        run_phase(30, 7'd1, 1'b0);
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        run_phase(30, 7'($urandom_range(65, 127)), 1'b0);
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        run_phase(30, 7'd64, 1'b0);
        hold_long = 1'b1;
        run_phase(30, 7'($urandom_range(0, 127)), 1'b0);
        run_phase(30, 7'($urandom_range(1, 64)), 1'b1);

        $display("Drove %0d samples and %0d tap loads, checked %0d results, %0d register writes",
                 trk.samples, trk.loads, trk.checked, trk.cfg_writes);
        $display("Tap counts from 0 to above 64, both output modes, random and long stalls");
        if (trk.errors == 0 && trk.pending_sums.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d errors, %0d results missing", trk.errors, trk.pending_sums.size());
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
